// ----- rtl/core/xks_pkg.sv -----
// Shared types, constants and the xorshift128+ step function for the
// keystream line cipher. No dependencies.
package xks_pkg;

  localparam logic [63:0] MIX_FIRST  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_SECOND = 64'h94D0_49BB_1331_11EB;
  localparam logic [63:0] SEED_FLIP  = 64'hAAAA_AAAA_5555_5555;
  localparam logic [63:0] KEY_RESET  = 64'h1234_5678_9ABC_DEF0;

  localparam int unsigned SHIFT_A = 23;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 26;

  localparam int unsigned FRAME_W = 6;

  typedef enum logic [1:0] {
    OP_WORD    = 2'd0,
    OP_BYTE    = 2'd1,
    OP_RESYNC  = 2'd2,
    OP_RESTART = 2'd3
  } xks_op_e;

  typedef enum logic [1:0] {
    ST_BOOT,
    ST_IDLE,
    ST_WARM
  } xks_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic step_out;   // advance generator and load output register
    logic byte_mode;  // keep only the low byte of the result
    logic warm_step;  // advance generator, drop the keystream
    logic resync;     // reload halves from seed, bump frame count
    logic restart;    // reload seed from key, clear frame count
  } xks_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;   // output register holds a beat that stays this cycle
  } xks_stat_t;

  typedef struct packed {
    logic [63:0] first;
    logic [63:0] second;
    logic [31:0] ks;
  } xks_gen_t;

  function automatic xks_gen_t gen_step(input logic [63:0] first,
                                        input logic [63:0] second);
    logic [63:0] a;
    xks_gen_t    r;
    a = first;
    a = a ^ (a << SHIFT_A);
    a = a ^ (a >> SHIFT_B);
    a = a ^ second ^ (second >> SHIFT_C);
    r.first  = second;
    r.second = a;
    r.ks     = a[31:0] + second[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/xks_dp.sv -----
// Datapath of the keystream line cipher: key, seed, frame count, generator
// halves and the output register. Depends on xks_pkg.
module xks_dp #(
  parameter int unsigned RESEED_PERIOD = 60
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xks_pkg::xks_cmd_t   cmd_i,
  output xks_pkg::xks_stat_t  stat_o,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [63:0]         cfg_key_i,
  input  logic [31:0]         plain_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         cipher_o
);
  import xks_pkg::*;

  localparam logic [FRAME_W-1:0] PERIOD = FRAME_W'(RESEED_PERIOD);

  logic [63:0]        key_q, seed_q, seed_d;
  logic [63:0]        first_q, first_d, second_q, second_d;
  logic [FRAME_W-1:0] frame_q, frame_d, frame_inc;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        cipher_q, cipher_d;
  xks_gen_t           gen;

  assign gen       = gen_step(first_q, second_q);
  assign frame_inc = frame_q + FRAME_W'(1);

  always_comb begin
    seed_d   = seed_q;
    frame_d  = frame_q;
    first_d  = first_q;
    second_d = second_q;
    priority if (cmd_i.restart) begin
      seed_d   = key_q;
      frame_d  = '0;
      first_d  = key_q ^ MIX_FIRST;
      second_d = key_q ^ MIX_SECOND;
    end else if (cmd_i.resync) begin
      first_d  = seed_q ^ MIX_FIRST;
      second_d = seed_q ^ MIX_SECOND;
      if (frame_inc >= PERIOD) begin
        frame_d = '0;
        seed_d  = seed_q ^ SEED_FLIP;
      end else begin
        frame_d = frame_inc;
      end
    end else if (cmd_i.step_out || cmd_i.warm_step) begin
      first_d  = gen.first;
      second_d = gen.second;
    end
  end

  always_comb begin
    cipher_d    = cipher_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.step_out) begin
      out_valid_d = 1'b1;
      cipher_d    = cmd_i.byte_mode ? {24'd0, plain_i[7:0] ^ gen.ks[7:0]}
                                    : plain_i ^ gen.ks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= KEY_RESET;
      seed_q      <= KEY_RESET;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        key_q <= cfg_key_i;
      end
      seed_q      <= seed_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
    cipher_q <= cipher_d;
  end

  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign cipher_o        = cipher_q;

`ifndef SYNTHESIS
  a_frame_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q < PERIOD)
    else $error("frame count reached reseed period");
  a_restart_clears_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.restart |=> frame_q == '0 && seed_q == $past(key_q))
    else $error("restart did not load seed from key");
  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_out |-> !(out_valid_q && out_stall_i))
    else $error("output beat overwritten while stalled");
`endif

endmodule

// ----- rtl/core/xks_ctrl.sv -----
// Controller of the keystream line cipher: boot restart, item decode and the
// warm-up sequencer. Depends on xks_pkg.
module xks_ctrl #(
  parameter int unsigned WARMUP_STEPS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  output logic                cfg_ready_o,
  input  xks_pkg::xks_stat_t  stat_i,
  output xks_pkg::xks_cmd_t   cmd_o
);
  import xks_pkg::*;

  localparam int unsigned CNT_W = (WARMUP_STEPS > 1) ? $clog2(WARMUP_STEPS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST =
    CNT_W'((WARMUP_STEPS == 0) ? 0 : WARMUP_STEPS - 1);
  localparam xks_state_e AFTER_LOAD = (WARMUP_STEPS == 0) ? ST_IDLE : ST_WARM;

  xks_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  xks_op_e          op;
  logic             ready, accept, last;

  assign op     = xks_op_e'(op_i);
  assign ready  = (state_q == ST_IDLE) && !stat_i.out_busy;
  assign accept = ready && in_valid_i;
  assign last   = (cnt_q == CNT_LAST);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_BOOT: state_d = AFTER_LOAD;
      ST_IDLE: begin
        if (accept && (op == OP_RESYNC || op == OP_RESTART)) begin
          state_d = AFTER_LOAD;
        end
      end
      ST_WARM: begin
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_BOOT;
    endcase
  end

  assign cnt_d = (state_q == ST_WARM && !last) ? cnt_q + CNT_W'(1) : '0;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_BOOT: cmd_o.restart = 1'b1;
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_WORD:    cmd_o.step_out = 1'b1;
            OP_BYTE: begin
              cmd_o.step_out  = 1'b1;
              cmd_o.byte_mode = 1'b1;
            end
            OP_RESYNC:  cmd_o.resync  = 1'b1;
            OP_RESTART: cmd_o.restart = 1'b1;
            default:    cmd_o = '0;
          endcase
        end
      end
      ST_WARM: cmd_o.warm_step = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o  = !ready;
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_warm_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WARM |-> in_stall_o && !cmd_o.step_out)
    else $error("item accepted during warm-up");
  a_load_enters_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.resync || cmd_o.restart) && WARMUP_STEPS != 0 |=>
      state_q == ST_WARM && cnt_q == '0)
    else $error("reload not followed by warm-up");
  a_warm_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WARM && last |=> state_q == ST_IDLE)
    else $error("warm-up overran its step count");
`endif

endmodule

// ----- rtl/core/xorshift_keystream_line_cipher.sv -----
// Top level of the xorshift128+ keystream line cipher.
// Instantiates xks_ctrl and xks_dp; depends on xks_pkg.
//
//   channel | handshake                  | payload
//   --------+----------------------------+----------------------
//   in      | in_valid_i  / in_stall_o   | op_i[1:0], plain_i[31:0]
//   out     | out_valid_o / out_stall_i  | cipher_o[31:0]
//   cfg     | cfg_valid_i / cfg_ready_o  | cfg_key_i[63:0]
//
// A word or tail-byte beat advances the single generator step unit once;
// the ciphertext lands in the output register next cycle.
// A resync or restart beat reloads the generator halves, then runs
// WARMUP_STEPS generator steps, one per cycle, on that same unit.
// After reset the block runs a restart from the reset key, so in_stall_o
// stays high through that restart and its warm-up.
// A stalled output beat holds, and in_stall_o stays high while it does.
module xorshift_keystream_line_cipher #(
  parameter int unsigned WARMUP_STEPS  = 10,
  parameter int unsigned RESEED_PERIOD = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] plain_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] cipher_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_key_i
);
  import xks_pkg::*;

  xks_cmd_t  cmd;
  xks_stat_t stat;

  // Decode beats, sequence boot and warm-up
  xks_ctrl #(
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold key, seed, frame count and generator; drive the output beat
  xks_dp #(
    .RESEED_PERIOD (RESEED_PERIOD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_key_i   (cfg_key_i),
    .plain_i     (plain_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cipher_o    (cipher_o)
  );

endmodule

// ----- test/xorshift_keystream_line_cipher_tb.sv -----
// Self-checking testbench for xorshift_keystream_line_cipher: a scoreboard class
// tracks the keystream generator, seed and frame count. Depends on xks_pkg.
module xorshift_keystream_line_cipher_tb;
  import xks_pkg::*;

  localparam int unsigned WARMUP_CNT  = 10;
  localparam int unsigned FRAME_WRAP  = 60;
  localparam int unsigned PHASE_BEATS = 250;
  localparam int unsigned CYCLE_LIMIT = 500000;
  // Cover a resync or restart still warming up after the last ciphertext beat.
  localparam int unsigned SETTLE_CYC  = WARMUP_CNT + 6;
  localparam int unsigned HOLD_CYC    = 400;

  // Track the cipher state and hold the ciphertext beats still owed by the block.
  class cipher_scoreboard;
    logic [63:0] key_reg;
    logic [63:0] seed;
    logic [63:0] half_a;
    logic [63:0] half_b;
    logic [5:0]  frames;
    logic [31:0] pending_cipher[$];
    int unsigned failures;

    function new();
      failures = 0;
      key_reg  = KEY_RESET;
      restart();
    endfunction

    // Step xorshift128+ once; only the low 32 bits of the sum are ever used.
    function logic [31:0] advance();
      logic [63:0] x;
      logic [63:0] y;
      x = half_a;
      y = half_b;
      half_a = y;
      x = x ^ (x << SHIFT_A);
      x = x ^ (x >> SHIFT_B);
      x = x ^ y ^ (y >> SHIFT_C);
      half_b = x;
      return x[31:0] + y[31:0];
    endfunction

    function void warm_up();
      for (int n = 0; n < WARMUP_CNT; n++) void'(advance());
    endfunction

    function void restart();
      seed   = key_reg;
      frames = '0;
      half_a = seed ^ MIX_FIRST;
      half_b = seed ^ MIX_SECOND;
      warm_up();
    endfunction

    // A key write only lands in the seed on the next restart.
    function void set_key(logic [63:0] k);
      key_reg = k;
    endfunction

    function void note_input(xks_op_e op, logic [31:0] plain);
      logic [31:0] ks;
      case (op)
        OP_WORD: begin
          ks = advance();
          pending_cipher.push_back(plain ^ ks);
        end
        OP_BYTE: begin
          ks = advance();
          pending_cipher.push_back({24'h0, plain[7:0] ^ ks[7:0]});
        end
        OP_RESYNC: begin
          // Reload from the seed as it stood before this beat, then maybe flip it.
          half_a = seed ^ MIX_FIRST;
          half_b = seed ^ MIX_SECOND;
          frames = frames + 6'd1;
          if (frames >= FRAME_WRAP) begin
            frames = '0;
            seed   = seed ^ SEED_FLIP;
          end
          warm_up();
        end
        default: restart();
      endcase
    endfunction

    function void check_cipher(logic [31:0] got);
      logic [31:0] want;
      if (pending_cipher.size() == 0) begin
        $error("cipher: beat with nothing pending, actual %h", got);
        failures++;
      end else begin
        want = pending_cipher.pop_front();
        if (got !== want) begin
          $error("cipher mismatch: expected %h, actual %h", want, got);
          failures++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_cipher.size();
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i        = OP_WORD;
  logic [31:0] plain_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] cipher_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_key_i   = '0;

  cipher_scoreboard board;

  // Idle knobs per phase, plus the request for one long output hold-off.
  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  bit          hold_wanted  = 1'b0;
  int unsigned cycle_count  = 0;

  xorshift_keystream_line_cipher #(
    .WARMUP_STEPS (WARMUP_CNT),
    .RESEED_PERIOD(FRAME_WRAP)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .plain_i    (plain_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cipher_o   (cipher_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_key_i  (cfg_key_i)
  );

  always #2 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Draw an idle count: often zero so that back-to-back stretches occur too.
  function automatic int unsigned pick_gap(bit on);
    if (!on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Favor the all-zero and all-one words now and then.
  function automatic logic [31:0] pick_plain();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: check every accepted beat, then stall for a drawn number of cycles.
  // A requested hold-off is counted here, while the sender keeps offering beats.
  initial begin
    int unsigned wait_left;
    int unsigned hold_left;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        board.check_cipher(cipher_o);
        wait_left = pick_gap(recv_idle_on);
      end
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left   = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one beat after a drawn gap and hold it until the block takes it.
  // Keep valid high across back-to-back beats; drop it only for a real gap.
  task automatic send_item(xks_op_e op, logic [31:0] plain);
    int unsigned gap;
    gap = pick_gap(send_idle_on);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    plain_i    <= plain;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(op, plain);
  endtask

  // Stop offering, wait for every owed beat, then let any warm-up finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_key(logic [63:0] k);
    cfg_valid_i <= 1'b1;
    cfg_key_i   <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_key(k);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed frames: a resync, up to three words, maybe a tail byte.
  // Issue one restart early so the new key takes effect, then run with only
  // rare noise restarts, so that the frame count can wrap and flip the seed.
  task automatic run_phase(int unsigned beats);
    int unsigned sent;
    int unsigned restart_at;
    int unsigned words;
    bit          restarted;
    xks_op_e     noise_op;
    sent       = 0;
    restarted  = 1'b0;
    restart_at = $urandom_range(5, 30);
    while (sent < beats) begin
      if (!restarted && sent >= restart_at) begin
        send_item(OP_RESTART, pick_plain());
        restarted = 1'b1;
        sent++;
      end else if ($urandom_range(0, 19) == 0) begin
        noise_op = ($urandom_range(0, 39) == 0) ? OP_RESTART
                                                : xks_op_e'($urandom_range(0, 2));
        send_item(noise_op, pick_plain());
        sent++;
      end else begin
        send_item(OP_RESYNC, pick_plain());
        sent++;
        words = $urandom_range(0, 3);
        repeat (words) send_item(OP_WORD, pick_plain());
        sent += words;
        if ($urandom_range(0, 1) == 1) begin
          send_item(OP_BYTE, pick_plain());
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [63:0] phase_key [4];
    board = new();
    phase_key[0] = 64'h0;
    phase_key[1] = 64'hFFFF_FFFF_FFFF_FFFF;
    phase_key[2] = {$urandom, $urandom};
    phase_key[3] = {$urandom, $urandom};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset key, field extremes, byte masking, back-to-back
    // resyncs and restarts, and a restart right after a resync.
    send_item(OP_WORD,    32'h0000_0000);
    send_item(OP_WORD,    32'hFFFF_FFFF);
    send_item(OP_BYTE,    32'hFFFF_FFFF);
    send_item(OP_BYTE,    32'h0000_0000);
    send_item(OP_WORD,    32'hA5A5_5A5A);
    send_item(OP_RESYNC,  32'hFFFF_FFFF);
    send_item(OP_WORD,    $urandom);
    send_item(OP_RESYNC,  32'h0000_0000);
    send_item(OP_RESYNC,  $urandom);
    send_item(OP_BYTE,    32'h0000_0080);
    send_item(OP_RESTART, $urandom);
    send_item(OP_WORD,    32'h0000_0001);
    send_item(OP_RESTART, 32'h0000_0000);
    send_item(OP_RESTART, 32'hFFFF_FFFF);
    send_item(OP_WORD,    32'h8000_0000);
    send_item(OP_RESYNC,  $urandom);
    send_item(OP_RESTART, $urandom);
    send_item(OP_BYTE,    32'h1234_567F);
    send_item(OP_WORD,    $urandom);
    drain();

    // Random phases, each under its own key and idle pattern. The sender
    // pauses at every boundary until all owed beats are back.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_on = 1'b1; recv_idle_on = 1'b1; end
        1: begin send_idle_on = 1'b0; recv_idle_on = 1'b0; end
        2: begin send_idle_on = 1'b0; recv_idle_on = 1'b1; end
        default: begin send_idle_on = 1'b1; recv_idle_on = 1'b0; end
      endcase
      write_key(phase_key[p]);
      // Back up the output for a long stretch so the block stalls its input.
      if (p == 2) hold_wanted = 1'b1;
      run_phase(PHASE_BEATS);
      drain();
    end

    if (board.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/xks_pkg.sv
rtl/core/xks_dp.sv
rtl/core/xks_ctrl.sv
rtl/core/xorshift_keystream_line_cipher.sv
test/xorshift_keystream_line_cipher_tb.sv
